### hw/rtl/pnguf_pkg.sv
// package of types, constants and the paeth predictor for the png scanline unfilter
`default_nettype none
package pnguf_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);

	localparam logic [7:0] FT_NONE  = 8'd0;
	localparam logic [7:0] FT_SUB   = 8'd1;
	localparam logic [7:0] FT_UP    = 8'd2;
	localparam logic [7:0] FT_AVG   = 8'd3;
	localparam logic [7:0] FT_PAETH = 8'd4;

	localparam logic [7:0] CFG_WIDTH  = 8'd0;
	localparam logic [7:0] CFG_HEIGHT = 8'd1;

	typedef enum logic [2:0] {
		FILT_NONE,
		FILT_SUB,
		FILT_UP,
		FILT_AVG,
		FILT_PAETH
	} filt_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             first_row;
		filt_t            mode;
		logic             unknown;
		logic             row_end;
		logic             image_end;
		logic [23:0]      rgb;
	} qent_t;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dc;
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		logic [7:0] r;
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
		pa = (da < 0) ? 10'(-da) : 10'(da);
		pb = (db < 0) ? 10'(-db) : 10'(db);
		pc = (dc < 0) ? 10'(-dc) : 10'(dc);
		if (pa <= pb && pa <= pc) begin
			r = a;
		end else if (pb <= pc) begin
			r = b;
		end else begin
			r = c;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/pnguf_front.sv
// front end: accepts pixels, tracks column and row, latches and classifies the row filter
`default_nettype none
module pnguf_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [23:0]          s_tdata,  // in_red, in_green, in_blue
	input  wire  [7:0]           s_tuser,  // filter_type
	input  wire  [12:0]          image_width,
	input  wire  [15:0]          image_height,
	input  wire                  full,
	output logic                 push,
	output pnguf_pkg::qent_t     push_data
);
	import pnguf_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [15:0]      row_q;
	logic [7:0]       filter_q;
	logic [COL_W-1:0] wlast;
	logic [15:0]      hlast;
	logic [COL_W-1:0] x;
	logic [7:0]       ftype;
	logic             row_end;
	logic             image_end;

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	always_comb begin
		if (image_width == 13'd0) begin
			wlast = '0;
		end else if (image_width > 13'(MAX_WIDTH)) begin
			wlast = COL_W'(MAX_WIDTH - 1);
		end else begin
			wlast = COL_W'(image_width - 13'd1);
		end
		hlast     = (image_height == 16'd0) ? 16'd0 : image_height - 16'd1;
		x         = (col_q >= wlast) ? wlast : col_q;
		ftype     = (x == '0) ? s_tuser : filter_q;
		row_end   = (x == wlast);
		image_end = row_end && (row_q >= hlast);
	end

	always_comb begin
		push_data.col       = x;
		push_data.first_row = (row_q == 16'd0);
		push_data.row_end   = row_end;
		push_data.image_end = image_end;
		push_data.rgb       = s_tdata;
		push_data.unknown   = 1'b0;
		case (ftype)
			FT_NONE:  push_data.mode = FILT_NONE;
			FT_SUB:   push_data.mode = FILT_SUB;
			FT_UP:    push_data.mode = FILT_UP;
			FT_AVG:   push_data.mode = FILT_AVG;
			FT_PAETH: push_data.mode = FILT_PAETH;
			default: begin
				push_data.mode    = FILT_NONE;
				push_data.unknown = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			filter_q <= '0;
		end else if (push) begin
			if (x == '0) begin
				filter_q <= s_tuser;
			end
			if (row_end) begin
				col_q <= '0;
				row_q <= image_end ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= x + COL_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/pnguf_fifo.sv
// short queue of classified pixels between front and back end
`default_nettype none
module pnguf_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire  pnguf_pkg::qent_t push_data,
	output logic                 full,
	input  wire                  pop,
	output pnguf_pkg::qent_t     head,
	output logic                 empty
);
	import pnguf_pkg::*;

	qent_t          ent_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QAW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QAW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAW+1)'(QDEPTH))
		else $error("queue count beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

### hw/rtl/pnguf_back.sv
// back end: line store, neighbour registers, filter reconstruction and output register
`default_nettype none
module pnguf_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  empty,
	input  wire  pnguf_pkg::qent_t head,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [23:0]          m_tdata,  // out_red, out_green, out_blue
	output logic                 m_tlast,  // row_end
	output logic [1:0]           m_tuser   // unknown_filter, image_end
);
	import pnguf_pkg::*;

	logic [23:0] mem [MAX_WIDTH];

	logic        v_s1;
	qent_t       ent_s1;
	logic [23:0] rd_s1;
	logic        byp_s1;
	logic [23:0] bypd_s1;
	logic [23:0] left_q;
	logic [23:0] ul_q;
	logic        out_v_q;
	logic [23:0] out_data_q;
	logic        out_last_q;
	logic [1:0]  out_user_q;

	logic        adv;
	logic [23:0] above;
	logic [23:0] res;
	logic [23:0] bsel;

	assign adv      = v_s1 && (!out_v_q || m_tready);
	assign pop      = !empty && (!v_s1 || adv);
	assign above    = byp_s1 ? bypd_s1 : rd_s1;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

	always_comb begin
		logic [7:0] xc;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] pred;
		logic [8:0] sum;
		res  = '0;
		bsel = '0;
		for (int i = 0; i < 3; i++) begin
			xc  = ent_s1.rgb[8*i +: 8];
			a   = (ent_s1.col != '0) ? left_q[8*i +: 8] : 8'd0;
			b   = ent_s1.first_row ? 8'd0 : above[8*i +: 8];
			c   = (ent_s1.col != '0 && !ent_s1.first_row) ? ul_q[8*i +: 8] : 8'd0;
			sum = {1'b0, a} + {1'b0, b};
			case (ent_s1.mode)
				FILT_SUB:   pred = a;
				FILT_UP:    pred = b;
				FILT_AVG:   pred = sum[8:1];
				FILT_PAETH: pred = paeth(a, b, c);
				default:    pred = 8'd0;
			endcase
			res[8*i +: 8]  = xc + pred;
			bsel[8*i +: 8] = b;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mem[ent_s1.col] <= res;
		end
		if (pop) begin
			rd_s1   <= mem[head.col];
			ent_s1  <= head;
			bypd_s1 <= res;
		end
		if (adv) begin
			left_q     <= res;
			ul_q       <= bsel;
			out_data_q <= res;
			out_last_q <= ent_s1.row_end;
			out_user_q <= {ent_s1.unknown, ent_s1.image_end};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			byp_s1  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				v_s1   <= 1'b1;
				byp_s1 <= adv && (ent_s1.col == head.col);
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	a_byp_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(byp_s1) |-> $past(adv))
		else $error("line store bypass without a preceding write");
	a_image_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ent_s1.image_end) |-> ent_s1.row_end)
		else $error("image end off a row end");
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_v_q && !m_tready) |-> !pop)
		else $error("stage overwritten while stalled");

endmodule
`default_nettype wire

### hw/rtl/png_rgb8_scanline_unfilter_unit.sv
// top level of the png rgb8 scanline unfilter: configuration registers, front end, queue, back end
// a pixel is registered in the queue, then in the back-end stage register, then in the output register
// throughput: one pixel per cycle while m_tready stays high, set by the left pixel loop in the back end
// the line store is read into a register as a pixel leaves the queue, with a bypass for a one-pixel-wide image
// reset: counters, latched filter and handshake state clear, width and height return to 1
// reset: the line store is not cleared, row 0 of each image never uses what it reads from it
`default_nettype none
module png_rgb8_scanline_unfilter_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // in_red, in_green, in_blue
	input  wire  [7:0]  s_tuser,   // filter_type
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // out_red, out_green, out_blue
	output logic        m_tlast,   // row_end
	output logic [1:0]  m_tuser,   // unknown_filter, image_end
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_index,
	input  wire  [15:0] cfg_data
);
	import pnguf_pkg::*;

	logic [12:0] width_q;
	logic [15:0] height_q;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	qent_t       push_data;
	qent_t       head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd1;
			height_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[12:0];
				CFG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	pnguf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.image_width  (width_q),
		.image_height (height_q),
		.full         (full),
		.push         (push),
		.push_data    (push_data)
	);

	pnguf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	pnguf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
